FILE: rtl/rsch_pkg.sv
// Shared types, constants and codes of the random split class histogram.
package rsch_pkg;

    localparam int MAX_CLASSES   = 16;
    localparam int SPLIT_SAMPLES = 10;

    localparam int VAL_W  = 32;
    localparam int SUM_W  = 36;
    localparam int BIN_W  = 48;
    localparam int CNT_W  = 20;
    localparam int NCLS_W = 5;
    localparam int CMD_W  = 2;
    localparam int CLS_W  = $clog2(MAX_CLASSES);
    localparam int ADDR_W = $clog2(2 * MAX_CLASSES);
    localparam int BINS   = 2 * MAX_CLASSES;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = NCLS_W;

    // The sample sum magnitude is divided by a reciprocal multiplication that is
    // exact for every magnitude of SUM_W bits.
    localparam int HALF_W     = SUM_W / 2;
    localparam int HI_W       = SUM_W - HALF_W;
    localparam int RCP_W      = SUM_W + 1;
    localparam int PART_W     = HI_W + RCP_W;
    localparam int PROD_W     = SUM_W + RCP_W;
    localparam int DIV_SHIFT  = SUM_W + $clog2(SPLIT_SAMPLES);
    localparam logic [RCP_W-1:0] DIV_RCP =
        RCP_W'(((longint'(1) <<< DIV_SHIFT) + longint'(SPLIT_SAMPLES) - 1)
               / longint'(SPLIT_SAMPLES));
    localparam int DIV_STEP_W = 2;

    localparam logic [DIV_STEP_W-1:0] DIV_MUL = 2'd0;
    localparam logic [DIV_STEP_W-1:0] DIV_SUM = 2'd1;
    localparam logic [DIV_STEP_W-1:0] DIV_SAT = 2'd2;

    localparam logic [BIN_W-1:0] BIN_MAX = {1'b0, {(BIN_W - 1){1'b1}}};
    localparam logic [BIN_W-1:0] BIN_MIN = {1'b1, {(BIN_W - 1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_START    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INSTANCE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES = 1'd1;

    localparam logic [NCLS_W-1:0] NCLS_RESET = 5'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_INST_RD,
        S_INST_WR,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_OUT
    } t_state;

endpackage

FILE: rtl/random_split_class_histogram.sv
// Top level of the random split class histogram with histogram control and emission.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+------------------------------------
//  input   | in        | i_valid / o_ready         | cmd, value, target, last
//  result  | out       | o_valid / i_ready         | split point, side, class, bin, count
//  config  | in        | i_cfg_valid / o_cfg_ready | register index and data
//
// A start word is taken in idle; for an instance word the bin store RAM is read,
// its registered data is updated and written back, then the next word or emission follows.
// A sample word holds the input until the three-step reciprocal-multiply divide by ten ends.
// Each emitted bin passes the read, load and output states and waits on any result stall.
// Reset and start clear the bins at once through per-entry valid bits.
module random_split_class_histogram (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [rsch_pkg::CMD_W-1:0]      i_cmd,
    input  logic signed [rsch_pkg::VAL_W-1:0] i_value,
    input  logic signed [rsch_pkg::VAL_W-1:0] i_target,
    input  logic                            i_last,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [rsch_pkg::VAL_W-1:0] o_split_mean,
    output logic                            o_side,
    output logic [rsch_pkg::CLS_W-1:0]      o_class_index,
    output logic signed [rsch_pkg::BIN_W-1:0] o_bin_value,
    output logic [rsch_pkg::CNT_W-1:0]      o_side_count,
    output logic                            o_done_res,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rsch_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rsch_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rsch_pkg::*;

    t_state r_state;
    t_state n_state;

    logic              r_mode;
    logic [NCLS_W-1:0] r_ncls;
    logic [BINS-1:0]   r_bin_vld;
    logic [CNT_W-1:0]  r_cnt [2];
    logic [ADDR_W-1:0] r_addr;
    logic              r_side;
    logic              r_upd;
    logic              r_last;
    logic [VAL_W-1:0]  r_tgt;

    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_split;
    logic              r_out_side;
    logic [CLS_W-1:0]  r_out_cls;
    logic [BIN_W-1:0]  r_out_bin;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_done;

    logic              in_acc;
    logic              split_start;
    logic              split_clear;
    logic              split_busy;
    logic [VAL_W-1:0]  split_value;
    logic              ram_we;
    logic [BIN_W-1:0]  ram_rdata;
    logic [NCLS_W-1:0] ncls_eff;
    logic              in_side;
    logic              tgt_ok;
    logic [BIN_W-1:0]  old_bin;
    logic [BIN_W:0]    reg_sum;
    logic [BIN_W-1:0]  n_bin;
    logic              emit_end_side;
    logic              emit_done;

    rsch_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (split_clear),
        .i_start (split_start),
        .i_value (i_value),
        .o_busy  (split_busy),
        .o_split (split_value)
    );

    rsch_ram #(
        .WIDTH (BIN_W),
        .DEPTH (BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (n_bin),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_ncls == '0) begin
            ncls_eff = NCLS_W'(1);
        end else if (r_ncls > NCLS_W'(MAX_CLASSES)) begin
            ncls_eff = NCLS_W'(MAX_CLASSES);
        end else begin
            ncls_eff = r_ncls;
        end
    end

    assign in_acc  = i_valid && o_ready;
    assign in_side = !(i_value < $signed(split_value));
    assign tgt_ok  = !i_target[VAL_W-1]
                  && (i_target[VAL_W-2:0] < (VAL_W - 1)'(ncls_eff));

    always_comb begin
        old_bin = r_bin_vld[r_addr] ? ram_rdata : '0;
        reg_sum = {old_bin[BIN_W-1], old_bin}
                + {{(BIN_W + 1 - VAL_W){r_tgt[VAL_W-1]}}, r_tgt};
        if (r_mode) begin
            if (reg_sum[BIN_W] != reg_sum[BIN_W-1]) begin
                n_bin = reg_sum[BIN_W] ? BIN_MIN : BIN_MAX;
            end else begin
                n_bin = reg_sum[BIN_W-1:0];
            end
        end else begin
            n_bin = (old_bin != BIN_MAX) ? old_bin + 1'b1 : old_bin;
        end
    end

    assign emit_end_side = ({1'b0, r_addr[CLS_W-1:0]} == NCLS_W'(ncls_eff - 1'b1));
    assign emit_done     = r_addr[ADDR_W-1] && emit_end_side;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_cmd == CMD_SAMPLE) begin
                        n_state = S_SPLIT;
                    end else if (i_cmd == CMD_INSTANCE) begin
                        n_state = S_INST_RD;
                    end
                end
            end
            S_SPLIT: begin
                if (!split_busy) begin
                    n_state = S_IDLE;
                end
            end
            S_INST_RD: n_state = S_INST_WR;
            S_INST_WR: n_state = r_last ? S_EMIT_RD : S_IDLE;
            S_EMIT_RD: n_state = S_EMIT_LD;
            S_EMIT_LD: n_state = S_EMIT_OUT;
            S_EMIT_OUT: begin
                if (i_ready) begin
                    n_state = r_out_done ? S_IDLE : S_EMIT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = (r_state == S_IDLE);
        split_start = in_acc && (i_cmd == CMD_SAMPLE);
        split_clear = in_acc && (i_cmd == CMD_START);
        ram_we      = (r_state == S_INST_WR) && r_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_ncls      <= NCLS_RESET;
            r_bin_vld   <= '0;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MODE:        r_mode <= i_cfg_data[0];
                    CFG_NUM_CLASSES: r_ncls <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_cmd == CMD_START)) begin
                        r_bin_vld <= '0;
                        r_cnt[0]  <= '0;
                        r_cnt[1]  <= '0;
                    end
                end
                S_INST_WR: begin
                    if (r_upd) begin
                        r_bin_vld[r_addr] <= 1'b1;
                    end
                    if (r_cnt[r_side] != CNT_MAX) begin
                        r_cnt[r_side] <= r_cnt[r_side] + 1'b1;
                    end
                end
                S_EMIT_LD: r_out_valid <= 1'b1;
                S_EMIT_OUT: begin
                    if (i_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_side <= in_side;
                    r_last <= i_last;
                    r_tgt  <= i_target;
                    r_upd  <= r_mode || tgt_ok;
                    r_addr <= r_mode ? {in_side, {CLS_W{1'b0}}}
                                     : {in_side, i_target[CLS_W-1:0]};
                end
            end
            S_INST_WR: begin
                if (r_last) begin
                    r_addr <= '0;
                end
            end
            S_EMIT_LD: begin
                r_out_split <= split_value;
                r_out_side  <= r_addr[ADDR_W-1];
                r_out_cls   <= r_addr[CLS_W-1:0];
                r_out_bin   <= r_bin_vld[r_addr] ? ram_rdata : '0;
                r_out_cnt   <= r_cnt[r_addr[ADDR_W-1]];
                r_out_done  <= emit_done;
            end
            S_EMIT_OUT: begin
                if (i_ready && !r_out_done) begin
                    r_addr <= emit_end_side ? {1'b1, {CLS_W{1'b0}}} : r_addr + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_out_valid;
    assign o_split_mean  = r_out_split;
    assign o_side        = r_out_side;
    assign o_class_index = r_out_cls;
    assign o_bin_value   = r_out_bin;
    assign o_side_count  = r_out_cnt;
    assign o_done_res    = r_out_done;

    a_out_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_EMIT_OUT))
        else $error("Result word shown outside the emission wait state.");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        split_busy |-> !o_ready)
        else $error("Input word accepted while the split divider is busy.");

    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_done_res) |=> (o_ready && !o_valid))
        else $error("Block did not return to idle after the final result word.");

    a_write_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ($past(r_state) == S_INST_RD))
        else $error("Bin store written without a preceding read.");

endmodule

FILE: rtl/rsch_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rsch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rsch_split.sv
// Sample accumulator and reciprocal-multiply divider that forms the split point.
module rsch_split (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_start,
    input  logic [rsch_pkg::VAL_W-1:0] i_value,
    output logic                       o_busy,
    output logic [rsch_pkg::VAL_W-1:0] o_split
);
    import rsch_pkg::*;

    logic [SUM_W-1:0]      r_sum;
    logic [VAL_W-1:0]      r_split;
    logic [SUM_W-1:0]      r_mag;
    logic                  r_neg;
    logic                  r_busy;
    logic [DIV_STEP_W-1:0] r_step;
    logic [PART_W-1:0]     r_prod_lo;
    logic [PART_W-1:0]     r_prod_hi;

    logic [SUM_W:0]        add_sum;
    logic [SUM_W-1:0]      n_sum;
    logic [PART_W-1:0]     n_prod_lo;
    logic [PART_W-1:0]     n_prod_hi;
    logic [PROD_W-1:0]     prod;
    logic [SUM_W-1:0]      n_quo;
    logic [VAL_W-1:0]      n_split;

    always_comb begin
        add_sum = {r_sum[SUM_W-1], r_sum}
                + {{(SUM_W + 1 - VAL_W){i_value[VAL_W-1]}}, i_value};
        if (add_sum[SUM_W] != add_sum[SUM_W-1]) begin
            n_sum = add_sum[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                   : {1'b0, {(SUM_W - 1){1'b1}}};
        end else begin
            n_sum = add_sum[SUM_W-1:0];
        end
    end

    always_comb begin
        n_prod_lo = {{(PART_W - HALF_W){1'b0}}, r_mag[HALF_W-1:0]}
                  * {{(PART_W - RCP_W){1'b0}}, DIV_RCP};
        n_prod_hi = {{(PART_W - HI_W){1'b0}}, r_mag[SUM_W-1:HALF_W]}
                  * {{(PART_W - RCP_W){1'b0}}, DIV_RCP};
        prod      = {r_prod_hi, {HALF_W{1'b0}}}
                  + {{(PROD_W - PART_W){1'b0}}, r_prod_lo};
        n_quo     = SUM_W'(prod >> DIV_SHIFT);
    end

    always_comb begin
        if (r_neg) begin
            if ((|r_mag[SUM_W-1:VAL_W]) || (r_mag[VAL_W-1] && (|r_mag[VAL_W-2:0]))) begin
                n_split = {1'b1, {(VAL_W - 1){1'b0}}};
            end else begin
                n_split = VAL_W'(~r_mag[VAL_W-1:0] + 1'b1);
            end
        end else begin
            if (|r_mag[SUM_W-1:VAL_W-1]) begin
                n_split = {1'b0, {(VAL_W - 1){1'b1}}};
            end else begin
                n_split = r_mag[VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sum   <= '0;
            r_split <= '0;
            r_busy  <= 1'b0;
            r_step  <= DIV_MUL;
        end else if (i_start) begin
            r_sum  <= n_sum;
            r_neg  <= n_sum[SUM_W-1];
            r_mag  <= n_sum[SUM_W-1] ? SUM_W'(~n_sum + 1'b1) : n_sum;
            r_step <= DIV_MUL;
            r_busy <= 1'b1;
        end else if (r_busy) begin
            case (r_step)
                DIV_MUL: begin
                    r_prod_lo <= n_prod_lo;
                    r_prod_hi <= n_prod_hi;
                    r_step    <= DIV_SUM;
                end
                DIV_SUM: begin
                    r_mag  <= n_quo;
                    r_step <= DIV_SAT;
                end
                DIV_SAT: begin
                    r_split <= n_split;
                    r_busy  <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assign o_busy  = r_busy;
    assign o_split = r_split;

endmodule
